[hw/rtl/rrps_pkg.sv]
// Shared types and constants for the round-robin process scheduler.
// No dependencies; imported by round_robin_process_scheduler and rrps_seq (rrps_ram does not use it).
`default_nettype none

package rrps_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   localparam logic [7:0] QUANTUM_RESET = 8'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] arrival;
      logic [15:0] remaining;
   } entry_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  job_tag;
      logic [15:0] arrival;
      logic [15:0] cost;
   } item_type;

   typedef struct packed {
      logic        load_accepted;
      logic        ran_valid;
      logic [7:0]  ran_tag;
      logic        finished;
      logic [15:0] turnaround;
      logic        table_empty;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/round_robin_process_scheduler.sv]
// A load reads and compares one entry at a time from the table end, shifting each later entry up
// until it finds its slot; a tick runs the current job and, when it finishes, removes its entry by
// shifting each later entry down. A new item is taken only while the sequencer is idle; one table RAM port pair.
// A result waits in the output register while the next item is accepted.
// Reset (synchronous, active high) empties the table, zeroes time and pointer, quantum = 3.
// Depends on rrps_pkg and rrps_seq.
`default_nettype none

module round_robin_process_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // job_tag[7:0], arrival[23:8], cost[39:24]
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // load_accepted, ran_valid, ran_tag[9:2],
                                         // finished, turnaround[26:11], table_empty, zero pad
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import rrps_pkg::*;

   logic       quantum_ff;
   logic [7:0] quantum_val_ff;
   logic       seq_idle;
   logic       seq_res_valid;
   logic       res_take;
   item_type   item;
   result_type seq_result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   assign item.cmd     = req_tuser;
   assign item.job_tag = req_tdata[7:0];
   assign item.arrival = req_tdata[23:8];
   assign item.cost    = req_tdata[39:24];

   assign req_tready = seq_idle;
   assign res_take   = !rsp_valid_ff || rsp_tready;

   rrps_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && seq_idle),
      .item      (item),
      .quantum   (quantum_val_ff),
      .idle      (seq_idle),
      .res_valid (seq_res_valid),
      .res_take  (res_take),
      .result    (seq_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_take) begin
         rsp_valid_in = seq_res_valid;
         rsp_res_in   = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         quantum_val_ff <= QUANTUM_RESET;
         quantum_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         quantum_ff   <= csr_wr_en;
         if (csr_wr_en) begin
            quantum_val_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_res_ff.table_empty,
                        rsp_res_ff.turnaround,
                        rsp_res_ff.finished,
                        rsp_res_ff.ran_tag,
                        rsp_res_ff.ran_valid,
                        rsp_res_ff.load_accepted};

   a_write_seen: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (quantum_ff && quantum_val_ff == $past(csr_wr_data)))
      else $error("quantum write lost");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && rsp_res_ff == $past(rsp_res_ff)))
      else $error("pending result overwritten");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      seq_res_valid |-> !req_tready)
      else $error("item accepted while result pending in sequencer");

endmodule

`default_nettype wire

[hw/rtl/rrps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/rrps_seq.sv]
// Scheduler sequencer: walks the job table one entry per step through a
// single compare/decrement unit. Depends on rrps_pkg and rrps_ram.
`default_nettype none

module rrps_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire rrps_pkg::item_type    item,
   input  wire logic [7:0]            quantum,
   output logic                       idle,
   output logic                       res_valid,
   input  wire logic                  res_take,
   output rrps_pkg::result_type       result
);
   import rrps_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_L_RD  = 4'd1;
   localparam logic [3:0] S_L_CMP = 4'd2;
   localparam logic [3:0] S_L_INS = 4'd3;
   localparam logic [3:0] S_T_CHK = 4'd4;
   localparam logic [3:0] S_D_RD  = 4'd5;
   localparam logic [3:0] S_D_WR  = 4'd6;
   localparam logic [3:0] S_P_RD  = 4'd7;
   localparam logic [3:0] S_P_CMP = 4'd8;
   localparam logic [3:0] S_T_END = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [7:0]       slice_ff, slice_in;
   logic [15:0]      now_ff, now_in;
   item_type         item_ff, item_in;
   result_type       res_ff, res_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   logic [IDX_W-1:0] c_start;
   logic [CNT_W-1:0] cnt_dec;
   logic [16:0]      now_next;
   logic [16:0]      tat_raw;
   logic [15:0]      rem_dec;
   logic [7:0]       slice_inc;
   logic [7:0]       q_eff;
   logic [CNT_W-1:0] k_inc;
   entry_type        new_entry;

   rrps_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      c_start   = (CNT_W'(cur_ff) >= cnt_ff) ? '0 : cur_ff;
      cnt_dec   = cnt_ff - CNT_W'(1);
      now_next  = {1'b0, now_ff} + 17'd1;
      tat_raw   = now_next - {1'b0, rd_data.arrival};
      rem_dec   = rd_data.remaining - 16'd1;
      slice_inc = (slice_ff == 8'hFF) ? slice_ff : slice_ff + 8'd1;
      q_eff     = (quantum == 8'd0) ? 8'd1 : quantum;
      k_inc     = k_ff + CNT_W'(1);
      new_entry.tag       = item_ff.job_tag;
      new_entry.arrival   = item_ff.arrival;
      new_entry.remaining = (item_ff.cost == 16'd0) ? 16'd1 : item_ff.cost;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      slice_in = slice_ff;
      now_in   = now_ff;
      item_in  = item_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_data  = rd_data;
      rd_addr  = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = c_start;
            if (start) begin
               item_in = item;
               res_in  = '0;
               if (item.cmd == CMD_LOAD) begin
                  k_in = cnt_ff;
                  if (cnt_ff == CNT_W'(MAX_JOBS)) begin
                     res_in.table_empty = 1'b0;
                     state_in = S_DONE;
                  end else if (cnt_ff == '0) begin
                     state_in = S_L_INS;
                  end else begin
                     state_in = S_L_RD;
                  end
               end else begin
                  cur_in = c_start;
                  state_in = (cnt_ff == '0) ? S_T_END : S_T_CHK;
               end
            end
         end
         S_L_RD: begin
            rd_addr  = IDX_W'(k_ff - CNT_W'(1));
            state_in = S_L_CMP;
         end
         S_L_CMP: begin
            if (rd_data.arrival > item_ff.arrival) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(k_ff);
               k_in     = k_ff - CNT_W'(1);
               state_in = (k_ff == CNT_W'(1)) ? S_L_INS : S_L_RD;
            end else begin
               state_in = S_L_INS;
            end
         end
         S_L_INS: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(k_ff);
            wr_data = new_entry;
            if (cnt_ff != '0 && k_ff <= CNT_W'(cur_ff) && CNT_W'(cur_ff) < cnt_ff) begin
               cur_in = cur_ff + IDX_W'(1);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            res_in.load_accepted = 1'b1;
            state_in = S_DONE;
         end
         S_T_CHK: begin
            if ({1'b0, rd_data.arrival} <= {1'b0, now_ff}) begin
               res_in.ran_valid = 1'b1;
               res_in.ran_tag   = rd_data.tag;
               slice_in         = slice_inc;
               wr_addr          = cur_ff;
               wr_data.remaining = rem_dec;
               if (rem_dec == 16'd0) begin
                  res_in.finished   = 1'b1;
                  res_in.turnaround = tat_raw[16] ? 16'hFFFF : tat_raw[15:0];
                  slice_in = 8'd0;
                  k_in     = CNT_W'(cur_ff);
                  if (CNT_W'(cur_ff) + CNT_W'(1) < cnt_ff) begin
                     state_in = S_D_RD;
                  end else begin
                     cnt_in   = cnt_dec;
                     cur_in   = '0;
                     state_in = S_T_END;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (slice_inc >= q_eff) begin
                     slice_in = 8'd0;
                     if (CNT_W'(cur_ff) + CNT_W'(1) >= cnt_ff) begin
                        cur_in   = '0;
                        state_in = S_T_END;
                     end else begin
                        cur_in   = cur_ff + IDX_W'(1);
                        state_in = S_P_RD;
                     end
                  end else begin
                     state_in = S_T_END;
                  end
               end
            end else begin
               state_in = S_T_END;
            end
         end
         S_D_RD: begin
            rd_addr  = IDX_W'(k_inc);
            state_in = S_D_WR;
         end
         S_D_WR: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(k_ff);
            k_in    = k_inc;
            if (k_inc + CNT_W'(1) < cnt_ff) begin
               state_in = S_D_RD;
            end else begin
               cnt_in = cnt_dec;
               if (CNT_W'(cur_ff) >= cnt_dec) begin
                  cur_in   = '0;
                  state_in = S_T_END;
               end else begin
                  state_in = S_P_RD;
               end
            end
         end
         S_P_RD: begin
            rd_addr  = cur_ff;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            if ({1'b0, rd_data.arrival} > now_next) begin
               cur_in = '0;
            end
            state_in = S_T_END;
         end
         S_T_END: begin
            if (now_ff != 16'hFFFF) begin
               now_in = now_ff + 16'd1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            res_in.table_empty = (cnt_ff == '0);
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         cnt_ff   <= '0;
         slice_ff <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         slice_ff <= slice_in;
         now_ff   <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      result = res_ff;
      result.table_empty = (cnt_ff == '0);
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_JOBS))
      else $error("job count beyond table size");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cnt_ff != '0) |-> (CNT_W'(cur_ff) < cnt_ff))
      else $error("pointer outside table while idle");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T_END) |=> (now_ff == $past(now_ff) + 16'd1 || now_ff == 16'hFFFF))
      else $error("time counter did not advance on tick");

   a_finish_ran: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ff.finished) |-> res_ff.ran_valid)
      else $error("finish reported without a run");

endmodule

`default_nettype wire

[test/round_robin_process_scheduler_checker.sv]
// Checker for the round-robin process scheduler: watches the item, result and CSR ports,
// predicts every result in its own job table model and compares field by field.
// Depends on rrps_pkg.
`default_nettype none

module round_robin_process_scheduler_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,   // job_tag[7:0], arrival[23:8], cost[39:24]
   input  wire logic        req_tuser,   // cmd
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // load_accepted, ran_valid, ran_tag[9:2],
                                         // finished, turnaround[26:11], table_empty, zero pad
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import rrps_pkg::*;

   entry_type  jobs [MAX_JOBS];
   int         job_count = 0;
   int         cursor = 0;
   int         slice_used = 0;
   int         now_tick = 0;
   logic [7:0] quantum = QUANTUM_RESET;
   result_type scheduler_results [$];
   int         mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic advance_schedule(input logic cmd, input logic [7:0] tag,
                                   input logic [15:0] arr, input logic [15:0] cost);
      result_type  r;
      int          pos;
      int          k;
      int          c;
      int          q;
      int          now;
      int          span;
      r = '0;
      if (cmd == CMD_LOAD) begin
         if (job_count < MAX_JOBS) begin
            pos = 0;
            while (pos < job_count && jobs[pos].arrival <= arr) pos++;
            for (k = job_count; k > pos; k--) jobs[k] = jobs[k - 1];
            jobs[pos].tag = tag;
            jobs[pos].arrival = arr;
            jobs[pos].remaining = (cost == 16'd0) ? 16'd1 : cost;
            if (job_count > 0 && pos <= cursor && cursor < job_count) cursor++;
            job_count++;
            r.load_accepted = 1'b1;
         end
      end else begin
         now = now_tick;
         q = (quantum == 8'd0) ? 1 : int'(quantum);
         if (cursor >= job_count) cursor = 0;
         if (job_count > 0 && int'(jobs[cursor].arrival) <= now) begin
            c = cursor;
            r.ran_valid = 1'b1;
            r.ran_tag = jobs[c].tag;
            jobs[c].remaining = jobs[c].remaining - 16'd1;
            if (slice_used < 255) slice_used++;
            if (jobs[c].remaining == 16'd0) begin
               span = now + 1 - int'(jobs[c].arrival);
               r.finished = 1'b1;
               r.turnaround = (span > 65535) ? 16'hFFFF : span[15:0];
               for (k = c; k + 1 < job_count; k++) jobs[k] = jobs[k + 1];
               job_count--;
               slice_used = 0;
               if (cursor >= job_count || int'(jobs[cursor].arrival) > now + 1) cursor = 0;
            end else if (slice_used >= q) begin
               slice_used = 0;
               if (c + 1 >= job_count) begin
                  cursor = 0;
               end else begin
                  cursor = c + 1;
                  if (int'(jobs[cursor].arrival) > now + 1) cursor = 0;
               end
            end
         end
         if (now_tick < 65535) now_tick++;
      end
      r.table_empty = (job_count == 0);
      scheduler_results = {scheduler_results, r};
   endtask

   function automatic int field_check(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         job_count = 0;
         cursor = 0;
         slice_used = 0;
         now_tick = 0;
         quantum = QUANTUM_RESET;
         scheduler_results.delete();
      end else begin
         if (csr_wr_en) quantum = csr_wr_data;
         if (req_tvalid && req_tready)
            advance_schedule(req_tuser, req_tdata[7:0], req_tdata[23:8], req_tdata[39:24]);
         if (rsp_tvalid && rsp_tready) begin
            if (scheduler_results.size() == 0) begin
               $error("result %h with no item outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = scheduler_results.pop_front();
               mismatches += field_check("load_accepted", want.load_accepted, rsp_tdata[0]);
               mismatches += field_check("ran_valid", want.ran_valid, rsp_tdata[1]);
               mismatches += field_check("ran_tag", want.ran_tag, rsp_tdata[9:2]);
               mismatches += field_check("finished", want.finished, rsp_tdata[10]);
               mismatches += field_check("turnaround", want.turnaround, rsp_tdata[26:11]);
               mismatches += field_check("table_empty", want.table_empty, rsp_tdata[27]);
            end
         end
      end
      fail_count <= mismatches;
      pending <= scheduler_results.size();
   end

endmodule

`default_nettype wire

[test/tb.sv]
// Top of the scheduler testbench: clock, reset, job and tick stimulus, CSR writes and verdict.
// Depends on rrps_pkg, round_robin_process_scheduler and round_robin_process_scheduler_checker.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrps_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 2 * MAX_JOBS + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;
   logic        calm = 1'b0;
   int          fail_count;
   int          pending;
   int          sched_now = 0;
   int          quiet = 0;

   round_robin_process_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   round_robin_process_scheduler_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic issue(input logic cmd, input logic [7:0] tag, input logic [15:0] arr,
                        input logic [15:0] cost);
      while (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {cost, arr, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_TICK && sched_now < 65535) sched_now++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_quantum(input logic [7:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          phase;
      int          load_pct;
      int          roll;
      int          a;
      logic [7:0]  q;
      logic [15:0] arr;
      logic [15:0] cost;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
      issue(CMD_LOAD, 8'hFF, 16'h0000, 16'h0000);
      issue(CMD_LOAD, 8'h00, 16'hFFFF, 16'hFFFF);
      issue(CMD_LOAD, 8'h11, 16'h0001, 16'h0004);
      issue(CMD_LOAD, 8'h22, 16'h0001, 16'h0002);
      repeat (2) issue(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
      issue(CMD_LOAD, 8'h33, 16'h0000, 16'h0005);
      repeat (6) issue(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
      issue(CMD_LOAD, 8'h44, 16'h0014, 16'h0001);
      repeat (6) issue(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom));

      for (phase = 0; phase < 12; phase++) begin
         settle();
         case (phase % 6)
            0: q = 8'd1;
            1: q = 8'd255;
            2: q = 8'd0;
            3: q = 8'd3;
            4: q = 8'($urandom_range(9, 2));
            default: q = 8'($urandom_range(255, 1));
         endcase
         set_quantum(q);
         load_pct = (phase % 3 == 0) ? 65 : ((phase % 3 == 1) ? 35 : 45);
         calm <= (phase == 5);
         repeat (120) begin
            if ($urandom_range(99) < load_pct) begin
               roll = $urandom_range(99);
               if (roll < 2) begin
                  arr = 16'($urandom_range(65535));
               end else begin
                  a = sched_now + int'($urandom_range(10)) - 4;
                  if (a < 0) a = 0;
                  arr = a[15:0];
               end
               roll = $urandom_range(99);
               if (roll < 8) begin
                  cost = 16'd0;
               end else if (roll < 85) begin
                  cost = 16'($urandom_range(6, 1));
               end else begin
                  cost = 16'($urandom_range(60, 7));
               end
               issue(CMD_LOAD, 8'($urandom), arr, cost);
            end else begin
               issue(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
            end
         end
      end

      calm <= 1'b0;
      settle();

      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
